FILE: design/hevsw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex star walk package
// Shared codes, stream widths, control word types and the walk program.
// ----------------------------------------------------------------------------
package hevsw_pkg;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int STATUS_W   = 2;
    localparam int PC_W       = 5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR   = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_PUSH     = 4'd1,
        OP_MUL      = 4'd2,
        OP_REM      = 4'd3,
        OP_RD_PREV  = 4'd4,
        OP_RD_CUR   = 4'd5,
        OP_RD_START = 4'd6,
        OP_TAKE     = 4'd7,
        OP_NEXT     = 4'd8,
        OP_DONE     = 4'd9,
        OP_ERR      = 4'd10
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER  = 3'd0,
        C_ALWAYS = 3'd1,
        C_FULL   = 3'd2,
        C_BND    = 3'd3,
        C_EQ     = 3'd4
    } t_cond;

    typedef struct packed {
        t_op              op;
        t_cond            cond;
        logic [PC_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic full;
        logic bnd;
        logic eq;
    } t_flags;

    localparam logic [PC_W-1:0] L_FWD   = 5'd0;
    localparam logic [PC_W-1:0] L_BACK  = 5'd8;
    localparam logic [PC_W-1:0] L_BSTEP = 5'd11;
    localparam logic [PC_W-1:0] L_ERR   = 5'd21;
    localparam logic [PC_W-1:0] L_DONE  = 5'd22;

    function automatic t_uword uw(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = uw(OP_PUSH,     C_FULL,   L_ERR);
            5'd1:    w = uw(OP_MUL,      C_NEVER,  L_FWD);
            5'd2:    w = uw(OP_REM,      C_NEVER,  L_FWD);
            5'd3:    w = uw(OP_RD_PREV,  C_NEVER,  L_FWD);
            5'd4:    w = uw(OP_TAKE,     C_NEVER,  L_FWD);
            5'd5:    w = uw(OP_NONE,     C_BND,    L_BACK);
            5'd6:    w = uw(OP_NONE,     C_EQ,     L_DONE);
            5'd7:    w = uw(OP_NONE,     C_ALWAYS, L_FWD);
            5'd8:    w = uw(OP_RD_START, C_NEVER,  L_FWD);
            5'd9:    w = uw(OP_TAKE,     C_NEVER,  L_FWD);
            5'd10:   w = uw(OP_NONE,     C_BND,    L_DONE);
            5'd11:   w = uw(OP_MUL,      C_NEVER,  L_FWD);
            5'd12:   w = uw(OP_REM,      C_NEVER,  L_FWD);
            5'd13:   w = uw(OP_NEXT,     C_NEVER,  L_FWD);
            5'd14:   w = uw(OP_NONE,     C_BND,    L_DONE);
            5'd15:   w = uw(OP_NONE,     C_EQ,     L_DONE);
            5'd16:   w = uw(OP_PUSH,     C_FULL,   L_ERR);
            5'd17:   w = uw(OP_RD_CUR,   C_NEVER,  L_FWD);
            5'd18:   w = uw(OP_TAKE,     C_NEVER,  L_FWD);
            5'd19:   w = uw(OP_NONE,     C_BND,    L_DONE);
            5'd20:   w = uw(OP_NONE,     C_ALWAYS, L_BSTEP);
            5'd21:   w = uw(OP_ERR,      C_NEVER,  L_FWD);
            default: w = uw(OP_DONE,     C_NEVER,  L_FWD);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

FILE: design/hevsw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hevsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

FILE: design/hevsw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walk sequencer
// Step counter over the program table with conditional jumps.
// ----------------------------------------------------------------------------
module hevsw_seq
    import hevsw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_start,
    input  wire logic   i_run,
    input  wire t_flags i_flags,
    output t_uword      o_uword
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          word;
    logic            jump;

    always_comb begin
        word = uprog(r_pc);
        case (word.cond)
            C_ALWAYS: jump = 1'b1;
            C_FULL:   jump = i_flags.full;
            C_BND:    jump = i_flags.bnd;
            C_EQ:     jump = i_flags.eq;
            default:  jump = 1'b0;
        endcase
        n_pc = jump ? word.target : PC_W'(r_pc + 1'b1);
        o_uword = word;
        if (!i_run) begin
            o_uword.op = OP_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= L_FWD;
        end else if (i_start) begin
            r_pc <= L_FWD;
        end else if (i_run) begin
            r_pc <= n_pc;
        end
    end

endmodule
`default_nettype wire

FILE: design/hevsw_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Walk datapath
// Current and start edge, face position by reciprocal multiply, neighbor
// arithmetic inside a face, and the star buffer write side.
// ----------------------------------------------------------------------------
module hevsw_dp
    import hevsw_pkg::*;
#(
    parameter int NUM_HALF_EDGES = 1024,
    parameter int FACE_SIZE      = 3,
    parameter int MAX_STAR       = 64
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_load,
    input  wire logic [$clog2(NUM_HALF_EDGES)-1:0] i_edge,
    input  wire t_uword                           i_uword,
    input  wire logic [$clog2(NUM_HALF_EDGES):0]  i_twin,
    output logic      [$clog2(NUM_HALF_EDGES)-1:0] o_rd_addr,
    output t_flags                                o_flags,
    output logic                                  o_push,
    output logic      [$clog2(MAX_STAR)-1:0]      o_push_addr,
    output logic      [$clog2(NUM_HALF_EDGES):0]  o_push_data,
    output logic      [$clog2(MAX_STAR+1)-1:0]    o_count
);

    localparam int EW    = $clog2(NUM_HALF_EDGES);
    localparam int PW    = $clog2(FACE_SIZE);
    localparam int SH    = EW + PW;
    localparam int PRW   = EW + SH;
    localparam int CW    = $clog2(MAX_STAR + 1);
    localparam int BAW   = $clog2(MAX_STAR);
    localparam int MAGIC = (2 ** SH) / FACE_SIZE;
    localparam logic [EW:0] NUM_X = (EW + 1)'(NUM_HALF_EDGES);
    localparam logic [EW:0] F_X   = (EW + 1)'(FACE_SIZE);
    localparam logic [EW:0] FM1_X = (EW + 1)'(FACE_SIZE - 1);
    localparam logic [PW-1:0] POS_LAST = PW'(FACE_SIZE - 1);

    logic [EW-1:0]  r_cur;
    logic [EW-1:0]  r_start;
    logic           r_bnd;
    logic           r_nb;
    logic           r_back;
    logic [CW-1:0]  r_count;
    logic [PRW-1:0] r_prod;
    logic [PW-1:0]  r_pos;

    logic [EW-1:0] q_est;
    logic [EW:0]   q_f;
    logic [EW:0]   rem_raw;
    logic [EW:0]   rem_fix;
    logic [EW:0]   cur_x;
    logic [EW:0]   prev_x;
    logic [EW:0]   next_x;
    logic          prev_bnd;
    logic          next_bnd;
    logic          full;

    always_comb begin
        q_est    = r_prod[PRW-1:SH];
        q_f      = (EW + 1)'({1'b0, q_est} * F_X);
        rem_raw  = {1'b0, r_cur} - q_f;
        rem_fix  = (rem_raw >= F_X) ? rem_raw - F_X : rem_raw;
        cur_x    = {1'b0, r_cur};
        prev_x   = (r_pos == '0) ? cur_x + FM1_X : cur_x - (EW + 1)'(1);
        next_x   = (r_pos == POS_LAST) ? cur_x - FM1_X : cur_x + (EW + 1)'(1);
        prev_bnd = prev_x >= NUM_X;
        next_bnd = next_x >= NUM_X;
        full     = r_count == CW'(MAX_STAR);

        case (i_uword.op)
            OP_RD_PREV:  o_rd_addr = prev_x[EW-1:0];
            OP_RD_START: o_rd_addr = r_start;
            default:     o_rd_addr = r_cur;
        endcase

        o_flags.full = full;
        o_flags.bnd  = r_bnd;
        o_flags.eq   = !r_bnd && (r_cur == r_start);
        o_push       = (i_uword.op == OP_PUSH) && !full;
        o_push_addr  = r_count[BAW-1:0];
        o_push_data  = {r_back, r_cur};
        o_count      = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd   <= 1'b0;
            r_nb    <= 1'b0;
            r_back  <= 1'b0;
            r_count <= '0;
        end else if (i_load) begin
            r_bnd   <= 1'b0;
            r_nb    <= 1'b0;
            r_back  <= 1'b0;
            r_count <= '0;
        end else begin
            case (i_uword.op)
                OP_PUSH: begin
                    if (!full) begin
                        r_count <= CW'(r_count + 1'b1);
                    end
                end
                OP_RD_PREV: begin
                    r_nb <= prev_bnd;
                end
                OP_RD_CUR: begin
                    r_nb <= 1'b0;
                end
                OP_RD_START: begin
                    r_nb   <= 1'b0;
                    r_back <= 1'b1;
                end
                OP_TAKE: begin
                    r_bnd <= i_twin[EW] | r_nb;
                end
                OP_NEXT: begin
                    r_bnd <= next_bnd;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur   <= i_edge;
            r_start <= i_edge;
        end else begin
            case (i_uword.op)
                OP_MUL:  r_prod <= PRW'(r_cur) * PRW'(MAGIC);
                OP_REM:  r_pos  <= rem_fix[PW-1:0];
                OP_TAKE: r_cur  <= i_twin[EW-1:0];
                OP_NEXT: r_cur  <= next_x[EW-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/half_edge_vertex_star_walk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Half-edge vertex star walk
// Twin table of a mesh and a microcoded walk around the vertex of a start
// half-edge; the star is collected in a buffer and then streamed out.
// ----------------------------------------------------------------------------
// A write request is taken in the idle state. A query walks the program with
// a twin table read in each forward and backward step, then streams the
// collected star from its buffer; queries are handled one at a time.
// An empty-star (bad index) or error result is loaded once the output is free.
// Reset clears all control state; the twin table holds no defined contents
// until written and gets no clearing pass.
// ----------------------------------------------------------------------------
module half_edge_vertex_star_walk
    import hevsw_pkg::*;
#(
    parameter int NUM_HALF_EDGES = 1024,
    parameter int FACE_SIZE      = 3,
    parameter int MAX_STAR       = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // edge_index[10:0], twin_value[21:11]
    input  wire logic                  s_tuser,   // action
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // half_edge[9:0], at_front[10]
    output logic      [STATUS_W-1:0]   m_tuser,   // status
    output logic                       m_tlast
);

    localparam int EW  = $clog2(NUM_HALF_EDGES);
    localparam int CW  = $clog2(MAX_STAR + 1);
    localparam int BAW = $clog2(MAX_STAR);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_WALK    = 5'b00010,
        S_SINGLE  = 5'b00100,
        S_EMIT_RD = 5'b01000,
        S_EMIT_LD = 5'b10000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic                  r_m_tvalid;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         n_idx;
    logic [STATUS_W-1:0]   r_status;
    logic [OUT_DATA_W-1:0] r_m_tdata;
    logic [STATUS_W-1:0]   r_m_tuser;
    logic                  r_m_tlast;

    logic [10:0]           idx;
    logic [10:0]           twv;
    logic                  idx_ok;
    logic                  twv_ok;
    logic [EW-1:0]         idx_e;
    logic [EW-1:0]         twv_e;
    logic                  accept;
    logic                  tw_wr;
    logic                  q_start;
    logic                  q_bad;
    logic                  out_free;
    logic                  load_single;
    logic                  load_edge;
    logic                  is_last;
    logic [OUT_DATA_W-1:0] edge_data;
    logic [31:0]           edge_wide;

    t_uword                uword;
    t_flags                flags;
    logic [EW:0]           twin_rd;
    logic [EW-1:0]         twin_addr;
    logic                  push;
    logic [BAW-1:0]        push_addr;
    logic [EW:0]           push_data;
    logic [EW:0]           buf_rd;
    logic [CW-1:0]         count;

    always_comb begin
        idx       = s_tdata[10:0];
        twv       = s_tdata[21:11];
        idx_ok    = !idx[10] && ({22'b0, idx[9:0]} < 32'(NUM_HALF_EDGES));
        twv_ok    = !twv[10] && ({22'b0, twv[9:0]} < 32'(NUM_HALF_EDGES));
        idx_e     = EW'({22'b0, idx[9:0]});
        twv_e     = EW'({22'b0, twv[9:0]});
        s_tready  = r_state == S_IDLE;
        accept    = s_tvalid && s_tready;
        tw_wr     = accept && (s_tuser == ACT_WRITE) && idx_ok;
        q_start   = accept && (s_tuser == ACT_QUERY) && idx_ok;
        q_bad     = accept && (s_tuser == ACT_QUERY) && !idx_ok;
        out_free  = !r_m_tvalid || m_tready;
        is_last   = CW'(r_idx + 1'b1) == count;
        edge_wide = 32'(buf_rd[EW-1:0]);
        edge_data = {5'b0, buf_rd[EW], edge_wide[9:0]};
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        load_single = 1'b0;
        load_edge   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (q_start) begin
                    n_state = S_WALK;
                end else if (q_bad) begin
                    n_state = S_SINGLE;
                end
            end
            S_WALK: begin
                if (uword.op == OP_DONE) begin
                    n_state = S_EMIT_RD;
                    n_idx   = '0;
                end else if (uword.op == OP_ERR) begin
                    n_state = S_SINGLE;
                end
            end
            S_SINGLE: begin
                if (out_free) begin
                    load_single = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    load_edge = 1'b1;
                    n_idx     = CW'(r_idx + 1'b1);
                    n_state   = is_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (load_single || load_edge) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_bad) begin
            r_status <= ST_EMPTY;
        end else if ((r_state == S_WALK) && (uword.op == OP_ERR)) begin
            r_status <= ST_ERR;
        end
        if (load_single) begin
            r_m_tdata <= '0;
            r_m_tuser <= r_status;
            r_m_tlast <= 1'b1;
        end else if (load_edge) begin
            r_m_tdata <= edge_data;
            r_m_tuser <= ST_OK;
            r_m_tlast <= is_last;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;
    assign m_tlast  = r_m_tlast;

    hevsw_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_run   (r_state == S_WALK),
        .i_flags (flags),
        .o_uword (uword)
    );

    hevsw_dp #(
        .NUM_HALF_EDGES (NUM_HALF_EDGES),
        .FACE_SIZE      (FACE_SIZE),
        .MAX_STAR       (MAX_STAR)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (q_start),
        .i_edge      (idx_e),
        .i_uword     (uword),
        .i_twin      (twin_rd),
        .o_rd_addr   (twin_addr),
        .o_flags     (flags),
        .o_push      (push),
        .o_push_addr (push_addr),
        .o_push_data (push_data),
        .o_count     (count)
    );

    hevsw_ram #(
        .WIDTH (EW + 1),
        .DEPTH (NUM_HALF_EDGES)
    ) u_twin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tw_wr),
        .i_wr_addr (idx_e),
        .i_wr_data ({!twv_ok, twv_e}),
        .i_rd_addr (twin_addr),
        .o_rd_data (twin_rd)
    );

    hevsw_ram #(
        .WIDTH (EW + 1),
        .DEPTH (MAX_STAR)
    ) u_star_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (push_addr),
        .i_wr_data (push_data),
        .i_rd_addr (r_idx[BAW-1:0]),
        .o_rd_data (buf_rd)
    );

endmodule
`default_nettype wire

FILE: design/hevsw_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex star walk port checker
// Checks result stream behavior seen on the ports of the top level.
// ----------------------------------------------------------------------------
module hevsw_chk
    import hevsw_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] i_m_tdata,
    input wire logic [STATUS_W-1:0]   i_m_tuser,
    input wire logic                  i_m_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("Result changed while stalled.");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == ST_OK) || (i_m_tuser == ST_EMPTY)
            || (i_m_tuser == ST_ERR))
        else $error("Result carries an unknown status.");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && ((i_m_tuser == ST_EMPTY) || (i_m_tuser == ST_ERR))
            |-> i_m_tlast && (i_m_tdata == '0))
        else $error("Empty or error result is not a lone zero result.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("Result valid right after reset.");

endmodule

bind half_edge_vertex_star_walk hevsw_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser),
    .i_m_tlast  (m_tlast)
);
`default_nettype wire
